### sv/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants, widths and operation codes of the grid bilinear sampler.
// ----------------------------------------------------------------------------
package gbs_pkg;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  localparam int MAX_COLUMNS   = 64;
  localparam int MAX_ROWS      = 64;
  localparam int FRACTION_BITS = 8;

  localparam int OP_W      = 2;
  localparam int CELL_W    = 6;
  localparam int POS_W     = 14;
  localparam int VALUE_W   = 16;
  localparam int GRAD_W    = 19;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam int COL_BITS = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_BITS + ROW_BITS;
  localparam int DEPTH    = MAX_COLUMNS * MAX_ROWS;
  localparam int INT_W    = POS_W - FRACTION_BITS;

  localparam int CRD_W = imax(imax(imax(CELL_W, INT_W) + 1, CFG_W),
                              imax(imax(COL_BITS, ROW_BITS),
                                   imax($clog2(MAX_COLUMNS + 1), $clog2(MAX_ROWS + 1))));

  localparam int D_W    = VALUE_W + 2;
  localparam int B_W    = VALUE_W + 1;
  localparam int PROD_W = D_W + FRACTION_BITS + 1;
  localparam int ACC_W  = GRAD_W;

  localparam int GRID_DIM_RESET = 64;

  localparam logic [OP_W-1:0] OP_WRITE  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_READ   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_SAMPLE = OP_W'(2);
  localparam logic [OP_W-1:0] OP_GRAD   = OP_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

endpackage

### sv/grid_bilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// grid_bilinear_sampler_unit
// Grid of Q7.8 cells with write, clamped read, bilinear sample and gradient,
// computed by one shared multiply-add unit under a small sequencer.
// ----------------------------------------------------------------------------
// write: no result; the sequencer stays idle, so further requests are taken without a stall
// read: one grid read through the fetch, drain and done states, result registered on leaving done
// sample: 4 grid reads then 3 multiply-add passes, each through prep, mul and add states
// gradient: 4 grid reads then 2 multiply-add passes; no new request is taken until the sequencer is idle again
// the single grid memory port and the shared multiplier serialize this work, and out_stall can hold done
// synchronous reset: sequencer idle, output empty, width and height 64, grid not cleared
module grid_bilinear_sampler_unit
  import gbs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OP_W-1:0]             in_op,
  input  logic [CELL_W-1:0]           in_cell_x,
  input  logic [CELL_W-1:0]           in_cell_y,
  input  logic signed [VALUE_W-1:0]   in_write_value,
  input  logic [POS_W-1:0]            in_pos_x,
  input  logic [POS_W-1:0]            in_pos_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VALUE_W-1:0]   out_result_value,
  output logic signed [GRAD_W-1:0]    out_grad_x,
  output logic signed [GRAD_W-1:0]    out_grad_y,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_PREP  = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  localparam logic [1:0] LAST_FETCH       = 2'd3;
  localparam logic [1:0] LAST_STEP_SAMPLE = 2'd2;
  localparam logic [1:0] LAST_STEP_GRAD   = 2'd1;

  function automatic logic [CRD_W-1:0] eff_limit(input logic [CFG_W-1:0] v, input int max_v);
    logic [CRD_W-1:0] e;
    e = CRD_W'(v);
    if (v == '0) begin
      e = CRD_W'(1);
    end else if (e > CRD_W'(max_v)) begin
      e = CRD_W'(max_v);
    end
    return e;
  endfunction

  function automatic logic [CRD_W-1:0] clamp_hi(input logic [CRD_W-1:0] v,
                                                input logic [CRD_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  state_t                     state_r, state_nxt;
  logic [CFG_W-1:0]           grid_width_r, grid_height_r;
  logic [OP_W-1:0]            op_r;
  logic [CRD_W-1:0]           x_r, y_r;
  logic [FRACTION_BITS-1:0]   fx_r, fy_r;
  logic [1:0]                 k_r, k_nxt;
  logic [1:0]                 step_r, step_nxt;
  logic                       cap_v_r;
  logic [1:0]                 cap_k_r;
  logic signed [VALUE_W-1:0]  p_r [4];
  logic signed [VALUE_W-1:0]  rdata_r;
  logic signed [D_W-1:0]      d_r, d_sel;
  logic signed [B_W-1:0]      b_r, b_sel;
  logic [FRACTION_BITS-1:0]   f_r, f_sel;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   sum_w;
  logic signed [ACC_W-1:0]    acc0_r, acc1_r;
  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  out_result_value_r;
  logic signed [GRAD_W-1:0]   out_grad_x_r, out_grad_y_r;

  logic signed [VALUE_W-1:0]  mem [DEPTH];

  logic [CRD_W-1:0]  width_eff, height_eff, wmax, hmax;
  logic [CRD_W-1:0]  xs, ys, xc, yc;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              accept, wr_ok, last_step, out_load;

  assign width_eff  = eff_limit(grid_width_r, MAX_COLUMNS);
  assign height_eff = eff_limit(grid_height_r, MAX_ROWS);
  assign wmax       = width_eff - CRD_W'(1);
  assign hmax       = height_eff - CRD_W'(1);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_ok    = accept && (in_op == OP_WRITE)
                    && (CRD_W'(in_cell_x) < width_eff) && (CRD_W'(in_cell_y) < height_eff);
  assign wr_addr  = {ROW_BITS'(in_cell_y), COL_BITS'(in_cell_x)};

  // neighbor k: bit 0 steps x, bit 1 steps y
  assign xs      = x_r + CRD_W'(k_r[0]);
  assign ys      = y_r + CRD_W'(k_r[1]);
  assign xc      = clamp_hi(xs, wmax);
  assign yc      = clamp_hi(ys, hmax);
  assign rd_addr = {yc[ROW_BITS-1:0], xc[COL_BITS-1:0]};

  assign last_step = (op_r == OP_GRAD) ? (step_r == LAST_STEP_GRAD)
                                       : (step_r == LAST_STEP_SAMPLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // grid memory
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= in_write_value;
    end
    rdata_r <= mem[rd_addr];
  end

  // operand select for the shared multiply-add
  always_comb begin
    d_sel = '0;
    b_sel = '0;
    f_sel = fx_r;
    if (op_r == OP_GRAD) begin
      d_sel = (D_W'(p_r[0]) - D_W'(p_r[1])) + (D_W'(p_r[3]) - D_W'(p_r[2]));
      if (step_r == 2'd0) begin
        b_sel = B_W'(p_r[1]) - B_W'(p_r[0]);
        f_sel = fy_r;
      end else begin
        b_sel = B_W'(p_r[2]) - B_W'(p_r[0]);
        f_sel = fx_r;
      end
    end else begin
      case (step_r)
        2'd0: begin
          d_sel = D_W'(p_r[1]) - D_W'(p_r[0]);
          b_sel = B_W'(p_r[0]);
          f_sel = fx_r;
        end
        2'd1: begin
          d_sel = D_W'(p_r[3]) - D_W'(p_r[2]);
          b_sel = B_W'(p_r[2]);
          f_sel = fx_r;
        end
        default: begin
          d_sel = D_W'(acc1_r) - D_W'(acc0_r);
          b_sel = B_W'(acc0_r);
          f_sel = fy_r;
        end
      endcase
    end
  end

  assign sum_w = PROD_W'(b_r) + (prod_r >>> FRACTION_BITS);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        k_nxt    = 2'd0;
        step_nxt = 2'd0;
        if (accept && (in_op != OP_WRITE)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if ((op_r == OP_READ) || (k_r == LAST_FETCH)) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_nxt = (op_r == OP_READ) ? ST_DONE : ST_PREP;
      end
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD: begin
        if (last_step) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = ST_PREP;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      k_r           <= 2'd0;
      step_r        <= 2'd0;
      cap_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      grid_width_r  <= CFG_W'(GRID_DIM_RESET);
      grid_height_r <= CFG_W'(GRID_DIM_RESET);
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
      cap_v_r <= (state_r == ST_FETCH);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
          REG_GRID_HEIGHT: grid_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      fx_r <= in_pos_x[FRACTION_BITS-1:0];
      fy_r <= in_pos_y[FRACTION_BITS-1:0];
      if (in_op == OP_READ) begin
        x_r <= CRD_W'(in_cell_x);
        y_r <= CRD_W'(in_cell_y);
      end else begin
        x_r <= CRD_W'(in_pos_x[POS_W-1:FRACTION_BITS]);
        y_r <= CRD_W'(in_pos_y[POS_W-1:FRACTION_BITS]);
      end
    end
    cap_k_r <= k_r;
    if (cap_v_r) begin
      p_r[cap_k_r] <= rdata_r;
    end
    if (state_r == ST_PREP) begin
      d_r <= d_sel;
      b_r <= b_sel;
      f_r <= f_sel;
    end
    if (state_r == ST_MUL) begin
      prod_r <= d_r * $signed({1'b0, f_r});
    end
    if (state_r == ST_ADD) begin
      if (step_r == 2'd1) begin
        acc1_r <= sum_w[ACC_W-1:0];
      end else begin
        acc0_r <= sum_w[ACC_W-1:0];
      end
    end
    if (out_load) begin
      case (op_r)
        OP_READ: begin
          out_result_value_r <= p_r[0];
          out_grad_x_r       <= '0;
          out_grad_y_r       <= '0;
        end
        OP_SAMPLE: begin
          out_result_value_r <= acc0_r[VALUE_W-1:0];
          out_grad_x_r       <= '0;
          out_grad_y_r       <= '0;
        end
        default: begin
          out_result_value_r <= '0;
          out_grad_x_r       <= acc0_r;
          out_grad_y_r       <= acc1_r;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_grad_x       = out_grad_x_r;
  assign out_grad_y       = out_grad_y_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output loaded outside the done state");

  a_grad_excludes_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_grad_x_r != '0 || out_grad_y_r != '0) |-> out_result_value_r == '0)
    else $error("gradient result carries a value");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_FETCH || state_r == ST_IDLE))
    else $error("accepted request did not start a fetch");

  a_grad_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) && (op_r == OP_GRAD) |-> step_r <= LAST_STEP_GRAD)
    else $error("gradient ran too many passes");

  a_drain_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> cap_v_r)
    else $error("drain without a pending grid read");

endmodule
